@@ sv/rsp_pkg.sv @@
// Shared constants, codes and types for the request slot pool.
`timescale 1ns / 1ps

package rsp_pkg;

  // Number of slots in the pool and the widths that follow from it.
  localparam int SLOTS  = 2048;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int SLOT_W = 11;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_WAIT     = 2'd2,
    OP_FREE     = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_PENDING = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  // One entry of the slot store: the done bit and the next-free link.
  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] next;
  } mem_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    mem_word_t         data;
  } mem_wr_t;

endpackage

@@ sv/rsp_in_if.sv @@
// Request channel interface: operation code and slot index.
`timescale 1ns / 1ps

interface rsp_in_if import rsp_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               opcode;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output opcode, output slot, input ready);
  modport sink (input valid, input opcode, input slot, output ready);
endinterface

@@ sv/rsp_out_if.sv @@
// Response channel interface: status, granted slot and prior done bit.
`timescale 1ns / 1ps

interface rsp_out_if import rsp_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] granted_slot;
  logic              slot_done;

  modport source (output valid, output status, output granted_slot, output slot_done,
                  input ready);
  modport sink (input valid, input status, input granted_slot, input slot_done,
                output ready);
endinterface

@@ sv/rsp_slot_mem.sv @@
// Slot store memory with registered read data and a clearing sweep after reset.
`timescale 1ns / 1ps

module rsp_slot_mem import rsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mem_rd_t   rd,
  output mem_word_t rd_data,
  input  mem_wr_t   wr,
  output logic      ready
);

  mem_word_t         mem_r [SLOTS];
  mem_word_t         rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_idx_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  mem_word_t         wr_data;

  // The sweep links every entry to its successor and clears its done bit.
  always_comb begin
    if (clr_busy_r) begin
      wr_en        = 1'b1;
      wr_addr      = clr_idx_r;
      wr_data.done = 1'b0;
      wr_data.next = PTR_W'(clr_idx_r) + PTR_W'(1);
    end else begin
      wr_en   = wr.en;
      wr_addr = wr.addr;
      wr_data = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + ADDR_W'(1);
      if (clr_idx_r == ADDR_W'(SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

@@ sv/request_slot_pool.sv @@
// Top level of the request slot pool: free list, done bits and response register.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid / ready      opcode (2), slot (11)
//   out_chan  out  valid / ready      status (2), granted_slot (11), slot_done (1)
//
// Each word is handled in two steps: the accept cycle reads the addressed entry of the
// slot store, and the execute state then modifies it, writes it back and loads the
// response register. The synchronous read of the slot store is why these steps are split.
// After reset a clearing sweep rebuilds the free list; in_chan.ready stays low until
// it is done. One word can be accepted while the previous response waits; it then
// stays in its execute state, with in_chan.ready low, until the response register is free.
`timescale 1ns / 1ps

module request_slot_pool import rsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rsp_in_if.sink     in_chan,
  rsp_out_if.source  out_chan
);

  // Control and captured request.
  fsm_t              state_r, state_nxt;
  op_t               op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PTR_W-1:0]  head_r, head_nxt;

  // Response register.
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] granted_r, granted_nxt;
  logic              done_r, done_nxt;

  // Slot store access.
  mem_rd_t           rd;
  mem_wr_t           wr;
  mem_word_t         rd_word;
  logic              mem_ready;

  logic              accept;
  logic              exec_fire;
  logic              pool_empty;
  logic              in_range;
  logic [PTR_W-1:0]  link;

  rsp_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .rd_data (rd_word),
    .wr      (wr),
    .ready   (mem_ready)
  );

  assign in_chan.ready = (state_r == S_IDLE) && mem_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Allocate reads the head entry; every other operation reads the addressed slot.
  always_comb begin
    rd.en   = accept;
    rd.addr = (in_chan.opcode == OP_ALLOC) ? head_r[ADDR_W-1:0] : ADDR_W'(in_chan.slot);
  end

  // State machine: each word passes through the execute state, held there while the response register is full.
  always_comb begin
    state_nxt = state_r;
    exec_fire = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_chan.ready) begin
          exec_fire = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pool_empty = head_r >= PTR_W'(SLOTS);
  assign in_range   = PTR_W'(slot_r) < PTR_W'(SLOTS);
  // A popped link at or above the pool size is treated as the end of the list.
  assign link       = (rd_word.next >= PTR_W'(SLOTS)) ? PTR_W'(SLOTS) : rd_word.next;

  // Read-modify-write of the entry fetched in the accept cycle.
  always_comb begin
    status_nxt   = ST_OK;
    granted_nxt  = slot_r;
    done_nxt     = 1'b0;
    head_nxt     = head_r;
    wr.en        = 1'b0;
    wr.addr      = addr_r;
    wr.data      = rd_word;
    unique case (op_r)
      OP_ALLOC: begin
        if (!pool_empty) begin
          done_nxt     = rd_word.done;
          granted_nxt  = SLOT_W'(head_r);
          head_nxt     = link;
          wr.en        = exec_fire;
          wr.data.done = 1'b0;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      OP_COMPLETE: begin
        if (in_range) begin
          done_nxt     = rd_word.done;
          wr.en        = exec_fire;
          wr.data.done = 1'b1;
        end
      end
      OP_WAIT: begin
        if (in_range) begin
          done_nxt = rd_word.done;
          if (rd_word.done) begin
            // The done bit stays set until the slot is allocated again.
            wr.en        = exec_fire;
            wr.data.next = head_r;
            head_nxt     = PTR_W'(slot_r);
          end else begin
            status_nxt = ST_PENDING;
          end
        end
      end
      OP_FREE: begin
        if (in_range) begin
          done_nxt     = rd_word.done;
          wr.en        = exec_fire;
          wr.data.next = head_r;
          head_nxt     = PTR_W'(slot_r);
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        head_r      <= head_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.opcode;
      slot_r <= in_chan.slot;
      addr_r <= rd.addr;
    end
    if (exec_fire) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.granted_slot = granted_r;
  assign out_chan.slot_done    = done_r;

  // The head pointer is a slot index or the null value, never beyond it.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PTR_W'(SLOTS))
    else $error("free list head beyond null value");

  // No word is taken before the clearing sweep has finished.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> mem_ready)
    else $error("word accepted during clearing sweep");

  // A successful allocate hands out the slot that was at the head.
  a_alloc_grants_head: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && (op_r == OP_ALLOC) && !pool_empty)
      |=> (out_chan.granted_slot == $past(SLOT_W'(head_r))))
    else $error("allocate did not grant the head slot");

  // A pending wait always reports the slot as not done.
  a_pending_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_PENDING)) |-> !out_chan.slot_done)
    else $error("pending status with done bit set");

endmodule
